// ===== rtl/spwm_pkg.sv =====
// Shared constants, control word and status types for the sparse weight matrix product core.
package spwm_pkg;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;

	localparam int MAX_ROWS     = 64;
	localparam int MAX_INNER    = 16;
	localparam int MAX_OUT_COLS = 16;

	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int INNER_W = $clog2(MAX_INNER);
	localparam int COL_W   = $clog2(MAX_OUT_COLS);

	// field and register widths
	localparam int OP_W     = 3;
	localparam int RIDX_W   = 6;
	localparam int CIDX_W   = 4;
	localparam int ROWCNT_W = 7;
	localparam int INNCNT_W = 5;
	localparam int COLCNT_W = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 7;

	localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
	localparam int B_DEPTH = MAX_INNER * MAX_OUT_COLS;
	localparam int A_AW    = ROW_W + INNER_W;
	localparam int B_AW    = INNER_W + COL_W;

	// exact sum of MAX_INNER full products
	localparam int ACC_W   = 2 * DATA_W + INNER_W;
	localparam int SAT_MSB = DATA_W + FRAC_W - 1;

	// opcodes
	localparam logic [OP_W-1:0] OP_WR_A = 3'd0;
	localparam logic [OP_W-1:0] OP_WR_B = 3'd1;
	localparam logic [OP_W-1:0] OP_RD_A = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
	localparam logic [OP_W-1:0] OP_CLR  = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_COL_COUNT = 2'd2;

	// microprogram addresses
	localparam int UPC_W = 4;
	localparam logic [UPC_W-1:0] U_FETCH  = 4'd0;
	localparam logic [UPC_W-1:0] U_DISP   = 4'd1;
	localparam logic [UPC_W-1:0] U_WR_A   = 4'd2;
	localparam logic [UPC_W-1:0] U_WR_B   = 4'd3;
	localparam logic [UPC_W-1:0] U_RD_A   = 4'd4;
	localparam logic [UPC_W-1:0] U_ERR    = 4'd5;
	localparam logic [UPC_W-1:0] U_MAC    = 4'd6;
	localparam logic [UPC_W-1:0] U_DRAIN1 = 4'd7;
	localparam logic [UPC_W-1:0] U_DRAIN2 = 4'd8;
	localparam logic [UPC_W-1:0] U_EMIT   = 4'd9;
	localparam logic [UPC_W-1:0] U_CLR    = 4'd10;

	// sequencing conditions; the hold kinds stay on the step until their flag is set
	localparam logic [2:0] C_NEXT   = 3'd0;
	localparam logic [2:0] C_JUMP   = 3'd1;
	localparam logic [2:0] C_ACCEPT = 3'd2;
	localparam logic [2:0] C_OUT    = 3'd3;
	localparam logic [2:0] C_KLOOP  = 3'd4;
	localparam logic [2:0] C_CLOOP  = 3'd5;
	localparam logic [2:0] C_DISP   = 3'd6;

	// result sources
	localparam logic [1:0] SRC_ERR = 2'd0;
	localparam logic [1:0] SRC_ARD = 2'd1;
	localparam logic [1:0] SRC_ACC = 2'd2;

	typedef struct packed {
		logic [2:0]       cond;
		logic [UPC_W-1:0] target;
		logic             in_ready;
		logic             we_a;
		logic             we_b;
		logic             clear;
		logic             mac_issue;
		logic             clr_acc;
		logic             load_out;
		logic [1:0]       out_src;
	} ctrl_t;

	typedef struct packed {
		logic            accepted;
		logic [OP_W-1:0] opcode;
		logic            a_ok;
		logic            b_ok;
		logic            p_ok;
		logic            inner_zero;
		logic            k_last;
		logic            clr_last;
		logic            out_free;
	} stat_t;

endpackage

// ===== rtl/spwm_req_if.sv =====
// Request channel: opcode, indexes and write value.
interface spwm_req_if import spwm_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          opcode;
	logic [RIDX_W-1:0]        row_index;
	logic [CIDX_W-1:0]        column_index;
	logic signed [DATA_W-1:0] write_value;

	modport source(output valid, opcode, row_index, column_index, write_value, input ready);
	modport sink(input valid, opcode, row_index, column_index, write_value, output ready);
endinterface

// ===== rtl/spwm_rsp_if.sv =====
// Response channel: read or product value and status.
interface spwm_rsp_if import spwm_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] read_value;
	logic                     status;

	modport source(output valid, read_value, status, input ready);
	modport sink(input valid, read_value, status, output ready);
endinterface

// ===== rtl/spwm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module spwm_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/spwm_useq.sv =====
// Microcode sequencer: control ROM, step counter and branch logic.
module spwm_useq import spwm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t st,
	output ctrl_t ctrl
);

	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] upc_nxt;
	logic [UPC_W-1:0] disp_tgt;
	logic             hold;

	function automatic ctrl_t urom(input logic [UPC_W-1:0] a);
		ctrl_t w;
		w = '0;
		case (a)
			U_FETCH: begin
				w.in_ready = 1'b1;
				w.cond     = C_ACCEPT;
				w.target   = U_DISP;
			end
			U_DISP: begin
				w.clr_acc = 1'b1;
				w.cond    = C_DISP;
			end
			U_WR_A: begin
				w.we_a   = 1'b1;
				w.cond   = C_JUMP;
				w.target = U_FETCH;
			end
			U_WR_B: begin
				w.we_b   = 1'b1;
				w.cond   = C_JUMP;
				w.target = U_FETCH;
			end
			U_RD_A: begin
				w.load_out = 1'b1;
				w.out_src  = SRC_ARD;
				w.cond     = C_OUT;
				w.target   = U_FETCH;
			end
			U_ERR: begin
				w.load_out = 1'b1;
				w.out_src  = SRC_ERR;
				w.cond     = C_OUT;
				w.target   = U_FETCH;
			end
			U_MAC: begin
				w.mac_issue = 1'b1;
				w.cond      = C_KLOOP;
				w.target    = U_DRAIN1;
			end
			U_DRAIN1: begin
				w.cond = C_NEXT;
			end
			U_DRAIN2: begin
				w.cond = C_NEXT;
			end
			U_EMIT: begin
				w.load_out = 1'b1;
				w.out_src  = SRC_ACC;
				w.cond     = C_OUT;
				w.target   = U_FETCH;
			end
			U_CLR: begin
				w.clear  = 1'b1;
				w.cond   = C_CLOOP;
				w.target = U_FETCH;
			end
			default: begin
				w.cond   = C_JUMP;
				w.target = U_FETCH;
			end
		endcase
		return w;
	endfunction

	assign ctrl = urom(upc_q);

	always_comb begin
		case (st.opcode)
			OP_WR_A: disp_tgt = st.a_ok ? U_WR_A : U_FETCH;
			OP_WR_B: disp_tgt = st.b_ok ? U_WR_B : U_FETCH;
			OP_RD_A: disp_tgt = st.a_ok ? U_RD_A : U_ERR;
			OP_MUL: begin
				if (!st.p_ok) begin
					disp_tgt = U_ERR;
				end else if (st.inner_zero) begin
					disp_tgt = U_EMIT;
				end else begin
					disp_tgt = U_MAC;
				end
			end
			OP_CLR:  disp_tgt = U_CLR;
			default: disp_tgt = U_FETCH;
		endcase
	end

	always_comb begin
		case (ctrl.cond)
			C_ACCEPT: hold = !st.accepted;
			C_OUT:    hold = !st.out_free;
			C_KLOOP:  hold = !st.k_last;
			C_CLOOP:  hold = !st.clr_last;
			default:  hold = 1'b0;
		endcase
		if (hold) begin
			upc_nxt = upc_q;
		end else if (ctrl.cond == C_NEXT) begin
			upc_nxt = upc_q + 1'b1;
		end else if (ctrl.cond == C_DISP) begin
			upc_nxt = disp_tgt;
		end else begin
			upc_nxt = ctrl.target;
		end
	end

	// reset starts with a clearing pass over both stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_CLR;
		end else begin
			upc_q <= upc_nxt;
		end
	end

`ifndef ASSERT_OFF
	a_upc_range: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q <= U_CLR)
		else $error("step counter left the program");

	a_mac_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == U_MAC && upc_nxt != U_MAC) |-> st.k_last)
		else $error("product loop left before the last term");

	a_clr_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == U_CLR && upc_nxt == U_FETCH) |-> st.clr_last)
		else $error("clearing pass ended early");
`endif

endmodule

// ===== rtl/spwm_dp.sv =====
// Datapath: config registers, item latch, both stores, MAC pipeline, result register.
module spwm_dp import spwm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	spwm_req_if.sink             req,
	spwm_rsp_if.source           rsp,
	input  ctrl_t                ctrl,
	output stat_t                st
);

	logic [ROWCNT_W-1:0] row_cnt_q;
	logic [INNCNT_W-1:0] inner_cnt_q;
	logic [COLCNT_W-1:0] col_cnt_q;
	logic [ROWCNT_W-1:0] rows_c;
	logic [INNCNT_W-1:0] inner_c;
	logic [COLCNT_W-1:0] cols_c;

	logic [OP_W-1:0]   op_q;
	logic [RIDX_W-1:0] r_q;
	logic [CIDX_W-1:0] c_q;
	logic [DATA_W-1:0] v_q;

	logic [INNER_W-1:0] k_q;
	logic [A_AW-1:0]    clr_cnt_q;

	logic              a_we;
	logic [A_AW-1:0]   a_waddr;
	logic [A_AW-1:0]   a_raddr;
	logic [DATA_W-1:0] a_wdata;
	logic [DATA_W-1:0] a_rdata;
	logic              b_we;
	logic [B_AW-1:0]   b_waddr;
	logic [B_AW-1:0]   b_raddr;
	logic [DATA_W-1:0] b_wdata;
	logic [DATA_W-1:0] b_rdata;

	logic                       issue_s1;
	logic                       vld_s2;
	logic signed [2*DATA_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic [DATA_W-1:0]          acc_sat;
	logic                       acc_fits;

	logic              out_vld_q;
	logic [DATA_W-1:0] out_val_q;
	logic              out_st_q;
	logic              out_free;
	logic              out_load;
	logic              accepted;

	// config registers, used clamped to the store bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q   <= '0;
			inner_cnt_q <= '0;
			col_cnt_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_COUNT:     row_cnt_q   <= cfg_wdata[ROWCNT_W-1:0];
				REG_INNER_COUNT:   inner_cnt_q <= cfg_wdata[INNCNT_W-1:0];
				REG_OUT_COL_COUNT: col_cnt_q   <= cfg_wdata[COLCNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign rows_c  = (row_cnt_q > ROWCNT_W'(MAX_ROWS)) ? ROWCNT_W'(MAX_ROWS) : row_cnt_q;
	assign inner_c = (inner_cnt_q > INNCNT_W'(MAX_INNER)) ? INNCNT_W'(MAX_INNER) : inner_cnt_q;
	assign cols_c  = (col_cnt_q > COLCNT_W'(MAX_OUT_COLS)) ? COLCNT_W'(MAX_OUT_COLS) : col_cnt_q;

	assign req.ready = ctrl.in_ready;
	assign accepted  = req.valid && ctrl.in_ready;

	always_ff @(posedge clk) begin
		if (accepted) begin
			op_q <= req.opcode;
			r_q  <= req.row_index;
			c_q  <= req.column_index;
			v_q  <= req.write_value;
		end
	end

	// inner term counter and clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (ctrl.clr_acc) begin
				k_q <= '0;
			end else if (ctrl.mac_issue) begin
				k_q <= k_q + 1'b1;
			end
			if (ctrl.clear) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	assign a_we    = ctrl.we_a || ctrl.clear;
	assign a_waddr = ctrl.clear ? clr_cnt_q : {r_q, c_q};
	assign a_wdata = ctrl.clear ? '0 : v_q;
	assign a_raddr = ctrl.mac_issue ? {r_q, k_q} : {r_q, c_q};

	// B rows are below the inner count, so the low row bits address it
	assign b_we    = ctrl.we_b || ctrl.clear;
	assign b_waddr = ctrl.clear ? clr_cnt_q[B_AW-1:0] : {r_q[INNER_W-1:0], c_q};
	assign b_wdata = ctrl.clear ? '0 : v_q;
	assign b_raddr = {k_q, c_q};

	spwm_ram #(.DEPTH(A_DEPTH), .WIDTH(DATA_W)) u_a_store (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	spwm_ram #(.DEPTH(B_DEPTH), .WIDTH(DATA_W)) u_b_store (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// read -> multiply -> accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			vld_s2   <= 1'b0;
		end else begin
			issue_s1 <= ctrl.mac_issue;
			vld_s2   <= issue_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(a_rdata) * $signed(b_rdata);
		if (ctrl.clr_acc) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// shifted sum fits when all bits above the kept window match the sign
	assign acc_fits = (&acc_q[ACC_W-1:SAT_MSB]) || !(|acc_q[ACC_W-1:SAT_MSB]);
	assign acc_sat  = acc_fits ? acc_q[SAT_MSB:FRAC_W]
		: (acc_q[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}});

	assign out_free = !out_vld_q || rsp.ready;
	assign out_load = ctrl.load_out && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			case (ctrl.out_src)
				SRC_ARD: begin
					out_val_q <= a_rdata;
					out_st_q  <= 1'b0;
				end
				SRC_ACC: begin
					out_val_q <= acc_sat;
					out_st_q  <= 1'b0;
				end
				default: begin
					out_val_q <= '0;
					out_st_q  <= 1'b1;
				end
			endcase
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.read_value = out_val_q;
	assign rsp.status     = out_st_q;

	assign st.accepted   = accepted;
	assign st.opcode     = op_q;
	assign st.a_ok       = ({1'b0, r_q} < rows_c) && ({1'b0, c_q} < inner_c);
	assign st.b_ok       = ({1'b0, r_q} < ROWCNT_W'(inner_c)) && ({1'b0, c_q} < cols_c);
	assign st.p_ok       = ({1'b0, r_q} < rows_c) && ({1'b0, c_q} < cols_c);
	assign st.inner_zero = (inner_c == '0);
	assign st.k_last     = ({1'b0, k_q} == inner_c - 1'b1);
	assign st.clr_last   = &clr_cnt_q;
	assign st.out_free   = out_free;

`ifndef ASSERT_OFF
	a_acc_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.load_out && ctrl.out_src == SRC_ACC) |-> (!issue_s1 && !vld_s2))
		else $error("sum taken while products still in flight");

	a_no_store_write_in_mac: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.mac_issue |-> !(a_we || b_we))
		else $error("store written during a product walk");

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clear |-> !req.ready)
		else $error("item accepted during a clearing pass");
`endif

endmodule

// ===== rtl/sparse_weight_matrix_product_core.sv =====
// Top level of the sparse weight matrix product core.
// Holds a 64x16 Q16.16 matrix A and a 16x16 matrix B in two RAMs and runs a small
// microprogram per request item. Items are taken one at a time; a finished result
// sits in an output register, so the next item can be taken while it waits.
// Out-of-range writes and unused opcodes are ignored; out-of-range reads and
// products return an error status, and a product with inner=0 skips the multiply loop.
// A product entry does one multiply-accumulate per cycle through the single read
// port of each store, plus a two-stage read/multiply drain. A read or product result
// waits while the output register still holds an earlier result. A clear, and the
// pass after reset, sweep 1024 store addresses one per cycle with input held off;
// config writes are taken at any time. Products use an exact 68-bit sum, a floor
// shift by 16 and saturation to signed 32 bits.
module sparse_weight_matrix_product_core import spwm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	spwm_req_if.sink             req,
	spwm_rsp_if.source           rsp
);

	ctrl_t ctrl;
	stat_t st;

	spwm_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctrl   (ctrl)
	);

	spwm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.ctrl      (ctrl),
		.st        (st)
	);

endmodule
